FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// define SYNTH to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SDP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SDP_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SDP_ASSERT(lbl, clk, rstn, prop)
`define SDP_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/sdp_pkg.sv
// shared constants and types of the disparity point projector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;
  localparam int IMAGE_DIM_MAX = 4096;
  localparam int DIV_W      = 40;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;
  localparam int DVS_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int CRD_W      = DIV_W + 1;

  localparam logic [47:0] ROT0_RST  = 48'h0000_0000_4000;
  localparam logic [47:0] ROT1_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT2_RST  = 48'h4000_0000_0000;
  localparam logic [31:0] LIMIT_RST = 32'h1900_001A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS,
    REG_FOCAL, REG_BASE, REG_PRINC, REG_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic       sx;
    logic       sy;
    logic [7:0] gray;
  } side_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] gray;
  } pose_side_t;
endpackage
`default_nettype wire

FILE: rtl/sdp_if.sv
// valid/ready channel interfaces for pixels in and points out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface sdp_in_if;
  logic              valid;
  logic              ready;
  logic [11:0]       pixel_column;
  logic [11:0]       pixel_row;
  logic signed [15:0] disparity;
  logic [7:0]        gray_level;
  modport source (output valid, pixel_column, pixel_row, disparity, gray_level,
                  input ready);
  modport sink (input valid, pixel_column, pixel_row, disparity, gray_level,
                output ready);
endinterface

interface sdp_out_if;
  logic              valid;
  logic              ready;
  logic              point_valid;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic [7:0]        point_gray;
  modport source (output valid, point_valid, world_x, world_y, world_z, point_gray,
                  input ready);
  modport sink (input valid, point_valid, world_x, world_y, world_z, point_gray,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/stereo_disparity_point_projector_unit.sv
// top level of the disparity point projector: config registers, range test,
// dividers and pose; depends on sdp_pkg, sdp_if, sdp_div, sdp_pose, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes one pixel per transaction and returns one point per transaction, in order.
// A new pixel is accepted every clock while the output side keeps up. In order,
// the pipeline holds a register of products, one of the depth-limit compare,
// ten stages of the pipelined dividers (four quotient bits each), a register of
// sign restore and the pose product, sum and saturation (output) registers.
// The whole pipeline stalls together while a result waits on the output.
// Configuration writes must only happen while no pixel is in flight.
module stereo_disparity_point_projector_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  sdp_in_if.sink                              in_ch,
  sdp_out_if.source                           out_ch,
  input  wire logic                           cfg_we_i,
  input  wire logic [sdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sdp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sdp_pkg::*;

  logic [47:0] rot0_q, rot1_q, rot2_q;
  logic [62:0] trans_q;
  logic [15:0] focal_q;
  logic [19:0] base_q;
  logic [31:0] princ_q;
  logic [31:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q  <= ROT0_RST;
      rot1_q  <= ROT1_RST;
      rot2_q  <= ROT2_RST;
      trans_q <= '0;
      focal_q <= '0;
      base_q  <= '0;
      princ_q <= '0;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROT0:  rot0_q  <= cfg_wdata_i[47:0];
        REG_ROT1:  rot1_q  <= cfg_wdata_i[47:0];
        REG_ROT2:  rot2_q  <= cfg_wdata_i[47:0];
        REG_TRANS: trans_q <= cfg_wdata_i;
        REG_FOCAL: focal_q <= cfg_wdata_i[15:0];
        REG_BASE:  base_q  <= cfg_wdata_i[19:0];
        REG_PRINC: princ_q <= cfg_wdata_i[31:0];
        REG_LIMIT: limit_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  logic       en;
  pose_side_t pside_o;

  assign en          = !pside_o.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: products
  side_t              a_q;
  logic signed [15:0] d_a_q;
  logic [35:0]        num_a_q;
  logic [30:0]        pmin_a_q, pmax_a_q;
  logic signed [38:0] dx_a_q, dy_a_q;
  logic signed [17:0] ux, vy;
  logic               flag;

  assign ux   = $signed({2'b00, in_ch.pixel_column, 4'b0}) - $signed({2'b00, princ_q[15:0]});
  assign vy   = $signed({2'b00, in_ch.pixel_row, 4'b0}) - $signed({2'b00, princ_q[31:16]});
  assign flag = (in_ch.disparity > 16'sd0)
             && (32'(in_ch.pixel_column) < IMAGE_DIM_MAX)
             && (32'(in_ch.pixel_row) < IMAGE_DIM_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_a_q    <= in_ch.disparity;
      num_a_q  <= 36'(focal_q) * 36'(base_q);
      pmin_a_q <= 31'(limit_q[15:0]) * 31'(in_ch.disparity[DVS_W-1:0]);
      pmax_a_q <= 31'(limit_q[31:16]) * 31'(in_ch.disparity[DVS_W-1:0]);
      dx_a_q   <= 39'(ux) * 39'($signed({1'b0, base_q}));
      dy_a_q   <= 39'(vy) * 39'($signed({1'b0, base_q}));
    end
  end

  // stage b: depth limit test and magnitudes for the dividers
  side_t            b_q;
  logic [DIV_W-1:0] zn_b_q, xn_b_q, yn_b_q;
  logic [DVS_W-1:0] dv_b_q;
  logic             ok_b;

  assign ok_b = a_q.ok && (39'(num_a_q) > {pmin_a_q, 8'b0})
                       && (39'(num_a_q) < {pmax_a_q, 8'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      zn_b_q <= DIV_W'(num_a_q);
      xn_b_q <= dx_a_q[38] ? DIV_W'(-dx_a_q) : DIV_W'(dx_a_q);
      yn_b_q <= dy_a_q[38] ? DIV_W'(-dy_a_q) : DIV_W'(dy_a_q);
      dv_b_q <= d_a_q[DVS_W-1:0];
    end
  end

  // side band through the divider stages
  side_t side_q [DIV_STAGES];
  side_t c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      side_q <= '{default: '0};
      c_q    <= '0;
    end else if (en) begin
      a_q <= '{valid: in_ch.valid, ok: flag, sx: 1'b0, sy: 1'b0,
               gray: in_ch.gray_level};
      b_q <= '{valid: a_q.valid, ok: ok_b, sx: dx_a_q[38], sy: dy_a_q[38],
               gray: a_q.gray};
      side_q[0] <= b_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
      c_q <= side_q[DIV_STAGES-1];
    end
  end

  logic [DIV_W-1:0] qz, qx, qy;

  sdp_div u_div_z (.clk_i, .en_i(en), .dividend_i(zn_b_q), .divisor_i(dv_b_q),
                   .quotient_o(qz));
  sdp_div u_div_x (.clk_i, .en_i(en), .dividend_i(xn_b_q), .divisor_i(dv_b_q),
                   .quotient_o(qx));
  sdp_div u_div_y (.clk_i, .en_i(en), .dividend_i(yn_b_q), .divisor_i(dv_b_q),
                   .quotient_o(qy));

  // stage c: restore signs of the camera coordinates
  logic signed [CRD_W-1:0] x_c_q, y_c_q, z_c_q;
  side_t                   sl;

  assign sl = side_q[DIV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_c_q <= sl.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      y_c_q <= sl.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      z_c_q <= $signed({1'b0, qz});
    end
  end

  sdp_pose u_pose (
    .clk_i, .rst_ni, .en_i(en),
    .side_i('{valid: c_q.valid, ok: c_q.ok, gray: c_q.gray}),
    .x_i(x_c_q), .y_i(y_c_q), .z_i(z_c_q),
    .rot0_i(rot0_q), .rot1_i(rot1_q), .rot2_i(rot2_q), .trans_i(trans_q),
    .side_o(pside_o),
    .wx_o(out_ch.world_x), .wy_o(out_ch.world_y), .wz_o(out_ch.world_z)
  );

  assign out_ch.valid       = pside_o.valid;
  assign out_ch.point_valid = pside_o.ok;
  assign out_ch.point_gray  = pside_o.gray;

  `SDP_ASSERT(a_drop_zeroes, clk_i, rst_ni,
    out_ch.valid && !out_ch.point_valid |-> out_ch.world_x == 0 &&
    out_ch.world_y == 0 && out_ch.world_z == 0 && out_ch.point_gray == 0)
  `SDP_ASSERT(a_bad_disp_drops, clk_i, rst_ni,
    en && a_q.valid && (d_a_q[15] || d_a_q == 16'sd0) |=> !b_q.ok)
  `SDP_NEVER(a_ok_needs_divisor, clk_i, rst_ni, b_q.valid && b_q.ok && dv_b_q == '0)
endmodule
`default_nettype wire

FILE: rtl/sdp_div.sv
// pipelined restoring divider, DIV_STEP quotient bits per stage
// depends on sdp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sdp_div (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [sdp_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [sdp_pkg::DVS_W-1:0] divisor_i,
  output logic      [sdp_pkg::DIV_W-1:0] quotient_o
);
  import sdp_pkg::*;

  logic [DIV_W-1:0] wrk_q [DIV_STAGES];
  logic [DVS_W-1:0] rem_q [DIV_STAGES];
  logic [DVS_W-1:0] dvs_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] w_src, w_d;
    logic [DVS_W-1:0] r_src, r_d, dv_src;
    logic [DVS_W:0]   t;

    if (s == 0) begin : g_first
      assign w_src  = dividend_i;
      assign r_src  = '0;
      assign dv_src = divisor_i;
    end else begin : g_next
      assign w_src  = wrk_q[s-1];
      assign r_src  = rem_q[s-1];
      assign dv_src = dvs_q[s-1];
    end

    // consumed dividend bits are replaced by quotient bits from the right
    always_comb begin
      w_d = w_src;
      r_d = r_src;
      t   = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
        t   = {r_d, w_d[DIV_W-1]};
        w_d = {w_d[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, dv_src}) begin
          t      = t - {1'b0, dv_src};
          w_d[0] = 1'b1;
        end
        r_d = t[DVS_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wrk_q[s] <= w_d;
        rem_q[s] <= r_d;
        dvs_q[s] <= dv_src;
      end
    end
  end

  assign quotient_o = wrk_q[DIV_STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/sdp_pose.sv
// rigid pose transform: products, rounded sum, saturation to q16.16, zero for dropped points
// depends on sdp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sdp_pose (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire sdp_pkg::pose_side_t         side_i,
  input  wire logic signed [sdp_pkg::CRD_W-1:0] x_i,
  input  wire logic signed [sdp_pkg::CRD_W-1:0] y_i,
  input  wire logic signed [sdp_pkg::CRD_W-1:0] z_i,
  input  wire logic [47:0]                 rot0_i,
  input  wire logic [47:0]                 rot1_i,
  input  wire logic [47:0]                 rot2_i,
  input  wire logic [62:0]                 trans_i,
  output sdp_pkg::pose_side_t              side_o,
  output logic signed [31:0]               wx_o,
  output logic signed [31:0]               wy_o,
  output logic signed [31:0]               wz_o
);
  import sdp_pkg::*;

  localparam int PRD_W = CRD_W + 16;

  logic [47:0]        rot [3];
  logic signed [PRD_W-1:0] prd_d [3][3];
  logic signed [PRD_W-1:0] prd_q [3][3];
  logic signed [45:0] rnd_d [3];
  logic signed [45:0] rnd_q [3];
  logic signed [31:0] sat_d [3];
  logic signed [31:0] sat_q [3];
  logic signed [CRD_W-1:0] crd [3];
  logic [59:0]        sum [3];
  pose_side_t         s1_q, s2_q, s3_q;

  assign rot = '{rot0_i, rot1_i, rot2_i};
  assign crd = '{x_i, y_i, z_i};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prd_d[r][c] = PRD_W'($signed(rot[r][16*c +: 16])) * PRD_W'(crd[c]);
      end
    end
  end

  // q.30 sum with translation scaled up, round half up, back to q.16
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 60'(prd_q[r][0]) + 60'(prd_q[r][1]) + 60'(prd_q[r][2])
             + (60'($signed(trans_i[21*r +: 21])) << 22) + 60'(8192);
      rnd_d[r] = $signed(sum[r][59:14]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (!s2_q.ok) begin
        sat_d[r] = '0;
      end else if (rnd_q[r][45:31] == '0 || rnd_q[r][45:31] == '1) begin
        sat_d[r] = rnd_q[r][31:0];
      end else if (rnd_q[r][45]) begin
        sat_d[r] = 32'sh8000_0000;
      end else begin
        sat_d[r] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prd_q <= prd_d;
      rnd_q <= rnd_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en_i) begin
      s1_q <= side_i;
      s2_q <= s1_q;
      s3_q <= '{valid: s2_q.valid, ok: s2_q.ok, gray: s2_q.ok ? s2_q.gray : 8'd0};
    end
  end

  assign side_o = s3_q;
  assign wx_o   = sat_q[0];
  assign wy_o   = sat_q[1];
  assign wz_o   = sat_q[2];
endmodule
`default_nettype wire
